FILE: hw/rtl/cosine_mixed_random_generator_core_assert.svh
// assertion macros for the checker file of the random generator core
// expects signals named clock and reset in the scope where a macro is used
`ifndef COSINE_MIXED_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define COSINE_MIXED_RANDOM_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define CMRG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CMRG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cmrg_pkg.sv
// shared types, constants and the cosine table of the random generator core
// no dependencies
package cmrg_pkg;

   localparam int DATA_W = 32;
   localparam int COS_W  = 18;
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int FRAC_W = 16;
   localparam int CNT_W  = $clog2(DATA_W);

   localparam logic [DATA_W-1:0] SEED_RESET      = '0;
   localparam logic [DATA_W-1:0] SEED_MULT_RESET = 32'd1;

   // register index taken from csr address bit 2
   localparam logic CSR_IDX_SEED_MULT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_COS,
      ST_PROD,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_DONE
   } cmrg_state_type;

   typedef enum logic {
      MUL_SEL_MIX,
      MUL_SEL_COS
   } cmrg_mul_sel_type;

   // quarter wave of cosine, unsigned 1.16, entry 64 is 1.0
   localparam logic [16:0] QUARTER_WAVE [0:64] = '{
      17'h00000, 17'h00648, 17'h00C8F, 17'h012D5, 17'h01917, 17'h01F56, 17'h02590, 17'h02BC4,
      17'h031F1, 17'h03817, 17'h03E33, 17'h04447, 17'h04A50, 17'h0504D, 17'h0563E, 17'h05C22,
      17'h061F7, 17'h067BD, 17'h06D74, 17'h07319, 17'h078AD, 17'h07E2E, 17'h0839C, 17'h088F5,
      17'h08E39, 17'h09368, 17'h0987F, 17'h09D7F, 17'h0A267, 17'h0A736, 17'h0ABEB, 17'h0B085,
      17'h0B504, 17'h0B968, 17'h0BDAE, 17'h0C1D8, 17'h0C5E4, 17'h0C9D1, 17'h0CD9F, 17'h0D14D,
      17'h0D4DB, 17'h0D848, 17'h0DB94, 17'h0DEBE, 17'h0E1C5, 17'h0E4AA, 17'h0E76B, 17'h0EA09,
      17'h0EC83, 17'h0EED8, 17'h0F109, 17'h0F314, 17'h0F4FA, 17'h0F6BA, 17'h0F853, 17'h0F9C7,
      17'h0FB14, 17'h0FC3B, 17'h0FD3A, 17'h0FE13, 17'h0FEC4, 17'h0FF4E, 17'h0FFB1, 17'h0FFEC,
      17'h10000
   };

   // byte order (b3,b2,b1,b0) -> (b0,b1,b3,b2)
   function automatic logic [DATA_W-1:0] cmrg_shuffle(input logic [DATA_W-1:0] s);
      return {s[7:0], s[15:8], s[31:24], s[23:16]};
   endfunction

   // cosine of an 8-bit angle with quadrant folding
   function automatic logic signed [COS_W-1:0] cmrg_cosine(input logic [7:0] angle);
      logic [6:0]  idx;
      logic        neg;
      logic [16:0] mag;
      case (angle[7:6])
         2'b00: begin
            idx = 7'd64 - {1'b0, angle[5:0]};
            neg = 1'b0;
         end
         2'b01: begin
            idx = {1'b0, angle[5:0]};
            neg = 1'b1;
         end
         2'b10: begin
            idx = 7'd64 - {1'b0, angle[5:0]};
            neg = 1'b1;
         end
         default: begin
            idx = {1'b0, angle[5:0]};
            neg = 1'b0;
         end
      endcase
      mag = QUARTER_WAVE[idx];
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

FILE: hw/rtl/cmrg_multiplier.sv
// shared signed multiplier with registered product
// depends on cmrg_pkg
module cmrg_multiplier
   import cmrg_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] product_ff
);

   logic signed [PROD_W-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

FILE: hw/rtl/cmrg_mod_unit.sv
// restoring remainder unit, one dividend bit per cycle
// depends on cmrg_pkg
module cmrg_mod_unit
   import cmrg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   assign trial = {rem_ff, dvd_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dvd_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit of diff is the borrow
         rem_in   = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
         dvd_in   = {dvd_ff[DATA_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/cosine_mixed_random_generator_core.sv
// top level of the cosine mixed random generator: sequencer, seed, csr and result register
// depends on cmrg_pkg, cmrg_multiplier and cmrg_mod_unit
//
//   channel | direction | tdata bits (low up)                | tuser
//   req     | in        | frame_time[31:0], upper_bound[63:32] | -
//   rsp     | out       | random_value[31:0]                  | bound_error
//   csr     | in/out    | seed_multiplier at byte address 0   | -
//
// an accepted request passes ST_MIX, ST_COS, ST_PROD, ST_MOD_START, ST_MOD_WAIT and ST_DONE
// up to rsp_tvalid, skipping ST_MOD_WAIT for a zero bound; the 32-step remainder unit is
// the longest part, the rest is two passes through the shared multiplier and cosine lookup.
// synchronous reset clears the seed to zero and the multiplier register to one.
// a waiting result sits in the output register, so the next request can be taken;
// a stalled rsp holds the sequencer only when a second result is ready.
module cosine_mixed_random_generator_core
   import cmrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // frame_time[31:0], upper_bound[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // random_value[31:0]
   output logic        rsp_tuser,   // bound_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmrg_state_type    state_ff, state_in;
   cmrg_mul_sel_type  mul_sel;
   logic              div_start;
   logic              div_done;

   logic [DATA_W-1:0] seed_ff, seed_in;
   logic [DATA_W-1:0] seed_mult_ff, seed_mult_in;
   logic [DATA_W-1:0] frame_ff, frame_in;
   logic [DATA_W-1:0] bound_ff, bound_in;
   logic signed [COS_W-1:0] cos_ff, cos_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic              error_ff, error_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              req_fire;
   logic              rsp_free;
   logic              csr_write;
   logic [DATA_W-1:0] mix_sum;
   logic [DATA_W-1:0] shuffled;
   logic signed [MUL_W-1:0]  op_a;
   logic signed [MUL_W-1:0]  op_b;
   logic signed [PROD_W-1:0] product;
   logic [DATA_W-1:0] remainder;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // seed*7 + frame_time, wrapping
   assign mix_sum  = {seed_ff[DATA_W-4:0], 3'b000} - seed_ff + frame_ff;
   assign shuffled = cmrg_shuffle(product[DATA_W-1:0]);

   always_comb begin
      if (mul_sel == MUL_SEL_MIX) begin
         op_a = $signed({1'b0, mix_sum});
         op_b = $signed({1'b0, seed_mult_ff});
      end else begin
         op_a = MUL_W'(cos_ff);
         op_b = $signed({seed_ff[DATA_W-1], seed_ff});
      end
   end

   cmrg_multiplier u_multiplier (
      .clock      (clock),
      .op_a       (op_a),
      .op_b       (op_b),
      .product_ff (product)
   );

   // product still holds cos * seed in ST_MOD_START, when the start is taken
   cmrg_mod_unit u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (product[FRAC_W+DATA_W-1:FRAC_W]),
      .divisor   (bound_ff),
      .done      (div_done),
      .remainder (remainder)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_fire) state_in = ST_MIX;
         ST_MIX:       state_in = ST_COS;
         ST_COS:       state_in = ST_PROD;
         ST_PROD:      state_in = ST_MOD_START;
         ST_MOD_START: state_in = (bound_ff == '0) ? ST_DONE : ST_MOD_WAIT;
         ST_MOD_WAIT:  if (div_done) state_in = ST_DONE;
         ST_DONE:      if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mul_sel    = MUL_SEL_MIX;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_MIX:       mul_sel = MUL_SEL_MIX;
         ST_COS:       mul_sel = MUL_SEL_MIX;
         ST_PROD:      mul_sel = MUL_SEL_COS;
         ST_MOD_START: div_start = (bound_ff != '0);
         ST_MOD_WAIT:  mul_sel = MUL_SEL_MIX;
         ST_DONE:      mul_sel = MUL_SEL_MIX;
         default:      req_tready = 1'b0;
      endcase
   end

   // datapath registers
   always_comb begin
      seed_in      = seed_ff;
      seed_mult_in = seed_mult_ff;
      frame_in     = frame_ff;
      bound_in     = bound_ff;
      cos_in       = cos_ff;
      result_in    = result_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;

      if (csr_write && csr_paddr[2] == CSR_IDX_SEED_MULT) begin
         seed_mult_in = csr_pwdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         frame_in = req_tdata[31:0];
         bound_in = req_tdata[63:32];
      end
      if (state_ff == ST_COS) begin
         seed_in = shuffled;
         cos_in  = cmrg_cosine(shuffled[7:0]);
      end
      if (state_ff == ST_MOD_START) begin
         result_in = '0;
         error_in  = (bound_ff == '0);
      end
      if (state_ff == ST_MOD_WAIT && div_done) begin
         result_in = remainder;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result_ff;
         rsp_err_in   = error_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         seed_mult_ff <= SEED_MULT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         seed_mult_ff <= seed_mult_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff    <= frame_in;
      bound_ff    <= bound_in;
      cos_ff      <= cos_in;
      result_ff   <= result_in;
      error_ff    <= error_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SEED_MULT) ? seed_mult_ff : '0;

endmodule

FILE: hw/rtl/cmrg_checker.sv
// port-level checks for the random generator core, bound to the top level
// depends on cosine_mixed_random_generator_core_assert.svh
`include "cosine_mixed_random_generator_core_assert.svh"

module cmrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   `CMRG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")

   `CMRG_ASSERT_NOW(a_error_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 32'd0, "bound error with nonzero value")

   // an accepted request keeps the block busy, so req_tready drops
   `CMRG_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "ready right after request")

   `CMRG_ASSERT_NOW(a_ready_drop, $fell(req_tready), $past(req_tvalid), "ready fell without a request")

endmodule

bind cosine_mixed_random_generator_core cmrg_checker u_cmrg_checker (.*);

FILE: sim/cosine_mixed_random_generator_core_checker.sv
`timescale 1ns / 100ps
// draw checker for the cosine mixed random generator core: follows the seed and multiplier,
// predicts one draw per accepted request and compares it with the rsp channel in order
// depends on cmrg_pkg for the csr register index
module cosine_mixed_random_generator_core_checker
   import cmrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // frame_time[31:0], upper_bound[63:32]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // random_value[31:0]
   input  logic        rsp_tuser,   // bound_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          pending,
   output int          fail_count
);

   localparam int REPORT_LIMIT = 10;

   // cosine over a quarter turn, 16.16, last entry is 1.0
   localparam int COS_TABLE [0:64] = '{
      'h00000, 'h00648, 'h00C8F, 'h012D5, 'h01917, 'h01F56, 'h02590, 'h02BC4,
      'h031F1, 'h03817, 'h03E33, 'h04447, 'h04A50, 'h0504D, 'h0563E, 'h05C22,
      'h061F7, 'h067BD, 'h06D74, 'h07319, 'h078AD, 'h07E2E, 'h0839C, 'h088F5,
      'h08E39, 'h09368, 'h0987F, 'h09D7F, 'h0A267, 'h0A736, 'h0ABEB, 'h0B085,
      'h0B504, 'h0B968, 'h0BDAE, 'h0C1D8, 'h0C5E4, 'h0C9D1, 'h0CD9F, 'h0D14D,
      'h0D4DB, 'h0D848, 'h0DB94, 'h0DEBE, 'h0E1C5, 'h0E4AA, 'h0E76B, 'h0EA09,
      'h0EC83, 'h0EED8, 'h0F109, 'h0F314, 'h0F4FA, 'h0F6BA, 'h0F853, 'h0F9C7,
      'h0FB14, 'h0FC3B, 'h0FD3A, 'h0FE13, 'h0FEC4, 'h0FF4E, 'h0FFB1, 'h0FFEC,
      'h10000
   };

   typedef struct packed {
      logic [31:0] value;
      logic        bound_error;
   } draw_type;

   logic [31:0] seed;
   logic [31:0] seed_mult;
   draw_type    draws_due [$];
   int          mismatch_count;
   int          results_seen;

   assign fail_count = mismatch_count + pending;

   function automatic logic [31:0] next_seed(input logic [31:0] cur, input logic [31:0] mult,
                                             input logic [31:0] frame_time);
      logic [31:0] s;
      s = mult * (cur * 32'd7 + frame_time);
      // (b3,b2,b1,b0) becomes (b0,b1,b3,b2)
      return {s[7:0], s[15:8], s[31:24], s[23:16]};
   endfunction

   function automatic int cosine_q16(input logic [7:0] angle);
      case (angle[7:6])
         2'd0: return COS_TABLE[64 - angle[5:0]];
         2'd1: return -COS_TABLE[angle[5:0]];
         2'd2: return -COS_TABLE[64 - angle[5:0]];
         default: return COS_TABLE[angle[5:0]];
      endcase
   endfunction

   function automatic draw_type draw_for(input logic [31:0] s, input logic [31:0] bound);
      draw_type    d;
      longint      product;
      logic [63:0] product_bits;
      logic [31:0] mixed;
      product = longint'(cosine_q16(s[7:0])) * longint'($signed(s));
      product_bits = product;
      mixed = product_bits[47:16];
      if (bound == '0) begin
         d.value = '0;
         d.bound_error = 1'b1;
      end else begin
         d.value = mixed % bound;
         d.bound_error = 1'b0;
      end
      return d;
   endfunction

   always @(posedge clock) begin
      draw_type    got;
      draw_type    want;
      logic [31:0] frame_time;
      logic [31:0] upper_bound;
      logic [31:0] new_seed;
      if (reset) begin
         seed <= '0;
         seed_mult <= 32'd1;
         draws_due.delete();
         mismatch_count <= 0;
         results_seen <= 0;
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata;
            got.bound_error = rsp_tuser;
            if (draws_due.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("draw %0d: none expected, got value %h bound_error %b",
                           results_seen, got.value, got.bound_error);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = draws_due.pop_front();
               if (got != want) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("draw %0d: expected value %h bound_error %b, got value %h bound_error %b",
                              results_seen, want.value, want.bound_error,
                              got.value, got.bound_error);
                  mismatch_count <= mismatch_count + 1;
               end
            end
            results_seen <= results_seen + 1;
         end
         if (req_tvalid && req_tready) begin
            frame_time = req_tdata[31:0];
            upper_bound = req_tdata[63:32];
            new_seed = next_seed(seed, seed_mult, frame_time);
            seed <= new_seed;
            draws_due.push_back(draw_for(new_seed, upper_bound));
         end
         // writes to an index past the register list are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == CSR_IDX_SEED_MULT)
            seed_mult <= csr_pwdata;
         pending <= draws_due.size();
      end
   end

endmodule

FILE: sim/cosine_mixed_random_generator_core_tb.sv
`timescale 1ns / 100ps
// top of the random generator core testbench: clock, reset, request and csr stimulus,
// rsp back-pressure, watchdog and verdict
// depends on cmrg_pkg, the core and cosine_mixed_random_generator_core_checker
module cosine_mixed_random_generator_core_tb;
   import cmrg_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int MAX_GAP        = 18;
   localparam int QUIET_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 118;

   localparam logic [2:0] ADDR_SEED_MULT = {CSR_IDX_SEED_MULT, 2'b00};
   localparam logic [2:0] ADDR_UNUSED    = {~CSR_IDX_SEED_MULT, 2'b00};

   localparam logic [31:0] PHASE_MULTS [0:3] = '{
      32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h0000_0007
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // frame_time[31:0], upper_bound[63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // random_value[31:0]
   logic        rsp_tuser;        // bound_error
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int   pending;
   int   fail_count;
   int   quiet_cycles = 0;
   logic steady_sender = 1'b0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   cosine_mixed_random_generator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cosine_mixed_random_generator_core_checker draw_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(input logic [31:0] frame_time, input logic [31:0] upper_bound);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {upper_bound, frame_time};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off until every outstanding request has its result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // a multiplier of zero forces the seed to zero, then ft selects the next angle directly
   task automatic aim_angle(input logic [7:0] angle, input logic [31:0] upper_bound);
      logic [31:0] rand_bits;
      rand_bits = $urandom;
      drain_results();
      write_csr(ADDR_SEED_MULT, 32'd0);
      send_request($urandom, $urandom_range(1, 255));
      drain_results();
      write_csr(ADDR_SEED_MULT, 32'd1);
      send_request({rand_bits[31:24], angle, rand_bits[15:0]}, upper_bound);
   endtask

   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom_range(1, 16);
         4:       return 32'd1 << $urandom_range(0, 31);
         5:       return 32'h8000_0000 | $urandom;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_frame_time();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 1023);
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // rsp back-pressure, with every third run of 40 results taken at full rate
   initial begin
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         stall = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      int p;
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset multiplier of one, seed starts at zero
      send_request(32'd0, 32'hFFFF_FFFF);
      send_request(32'd0, 32'd0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'h8000_0000, 32'h8000_0000);
      send_request($urandom, 32'd1);

      // write past the register list, multiplier must stay at one
      drain_results();
      write_csr(ADDR_UNUSED, 32'h0000_0005);
      send_request($urandom, $urandom);

      aim_angle(8'd64, $urandom);
      aim_angle(8'd128, 32'hFFFF_FFFF);
      aim_angle(8'd192, 32'd0);
      aim_angle(8'd63, 32'hFFFF_FFFF);
      aim_angle(8'd255, 32'h7FFF_FFFF);

      drain_results();
      write_csr(ADDR_SEED_MULT, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'd0);
      send_request($urandom, 32'hFFFF_FFFF);
      send_request($urandom, 32'd3);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         write_csr(ADDR_SEED_MULT, (p < 4) ? PHASE_MULTS[p] : $urandom);
         for (i = 0; i < PHASE_REQUESTS; i++) begin
            steady_sender = (i % 48) < 12;
            send_request(pick_frame_time(), pick_bound());
         end
         steady_sender = 1'b0;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cmrg_pkg.sv
hw/rtl/cmrg_multiplier.sv
hw/rtl/cmrg_mod_unit.sv
hw/rtl/cosine_mixed_random_generator_core.sv
hw/rtl/cmrg_checker.sv
sim/cosine_mixed_random_generator_core_checker.sv
sim/cosine_mixed_random_generator_core_tb.sv
